// ===== hw/rtl/exptok_pkg.sv =====
// Package for the expression tokenizer: character codes, token kinds,
// error codes, run codes, mask register indices and the structs passed between its modules.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package exptok_pkg;

    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [1:0] KIND_NUMBER   = 2'd0;
    localparam logic [1:0] KIND_NAME     = 2'd1;
    localparam logic [1:0] KIND_OPERATOR = 2'd2;
    localparam logic [1:0] KIND_BRACKET  = 2'd3;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN = 2'd1;
    localparam logic [1:0] ERR_DOTS    = 2'd2;

    localparam logic [1:0] RUN_NONE   = 2'd0;
    localparam logic [1:0] RUN_NUMBER = 2'd1;
    localparam logic [1:0] RUN_NAME   = 2'd2;

    localparam logic CFG_MASK_LOW  = 1'b0;
    localparam logic CFG_MASK_HIGH = 1'b1;

    typedef struct packed {
        logic       after_operator;
        logic [1:0] run_kind;
        logic       dot_seen;
        logic       failed;
    } t_lex_state;

    typedef struct packed {
        logic [7:0] token_char;
        logic       token_start;
        logic [1:0] token_kind;
        logic [1:0] error_code;
    } t_token;

endpackage

`default_nettype wire

// ===== hw/rtl/exptok_if.sv =====
// Handshake interfaces for the expression tokenizer: the character
// channel and the token channel. Independent of the package.
`timescale 1ns / 1ps
`default_nettype none

interface exptok_sym_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       expression_start;

    modport source (output valid, output symbol, output expression_start, input ready);
    modport sink   (input valid, input symbol, input expression_start, output ready);
endinterface

interface exptok_tok_if;
    logic       valid;
    logic       ready;
    logic [7:0] token_char;
    logic       token_start;
    logic [1:0] token_kind;
    logic [1:0] error_code;

    modport source (output valid, output token_char, output token_start,
                    output token_kind, output error_code, input ready);
    modport sink   (input valid, input token_char, input token_start,
                    input token_kind, input error_code, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/expression_tokenizer.sv =====
// Top level of the expression tokenizer: input register, run state, operator
// mask registers and token output register around the lexer logic.
// Depends on exptok_pkg, exptok_if and exptok_lex.
`timescale 1ns / 1ps
`default_nettype none

//  Channel   Direction  Word contents
//  i_sym     in         symbol[7:0], expression_start
//  o_tok     out        token_char[7:0], token_start, token_kind[1:0], error_code[1:0]
//  i_cfg_*   in         write enable, register index, 64-bit data (no handshake)
//
//  One character per clock sustained while o_tok is not stalled; a word accepted sits in
//  the input register, and its token, if it makes one, then enters the output register
//  and shows on o_tok from there.
//  The loop through the run state and the lexer logic sets this rate.
//  Reset puts the run state at its start (after an operator, no run, no dot, not failed)
//  and clears both operator masks and both valid flags. When o_tok stalls, the pipeline
//  holds and i_sym.ready drops only if the input register is also full.

module expression_tokenizer
    import exptok_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    exptok_sym_if.sink       i_sym,
    exptok_tok_if.source     o_tok,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);

    // Input register stage.
    logic       r_s1_valid;
    logic [7:0] r_s1_symbol;
    logic       r_s1_start;

    // Run state carried from one character to the next.
    t_lex_state r_state;
    t_lex_state n_state;

    logic [63:0] r_mask_low;
    logic [63:0] r_mask_high;

    // Output register stage.
    logic   r_out_valid;
    t_token r_out;
    t_token n_token;
    logic   n_emit;

    logic advance;

    // The lexer stage moves whenever the output register is free or being taken.
    assign advance     = !r_out_valid || o_tok.ready;
    assign i_sym.ready = !r_s1_valid || advance;

    exptok_lex u_lex (
        .i_symbol           (r_s1_symbol),
        .i_expression_start (r_s1_start),
        .i_state            (r_state),
        .i_mask_low         (r_mask_low),
        .i_mask_high        (r_mask_high),
        .o_state            (n_state),
        .o_emit             (n_emit),
        .o_token            (n_token)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_sym.ready) begin
            r_s1_valid <= i_sym.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sym.ready && i_sym.valid) begin
            r_s1_symbol <= i_sym.symbol;
            r_s1_start  <= i_sym.expression_start;
        end
    end

    // The run state only moves when a character is actually consumed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.after_operator <= 1'b1;
            r_state.run_kind       <= RUN_NONE;
            r_state.dot_seen       <= 1'b0;
            r_state.failed         <= 1'b0;
        end else if (advance && r_s1_valid) begin
            r_state <= n_state;
        end
    end

    // Mask writes must arrive only while the block is idle; the block itself does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_low  <= '0;
            r_mask_high <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MASK_LOW:  r_mask_low  <= i_cfg_data;
                CFG_MASK_HIGH: r_mask_high <= i_cfg_data;
                default:       r_mask_low  <= r_mask_low;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid && n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_token;
        end
    end

    assign o_tok.valid       = r_out_valid;
    assign o_tok.token_char  = r_out.token_char;
    assign o_tok.token_start = r_out.token_start;
    assign o_tok.token_kind  = r_out.token_kind;
    assign o_tok.error_code  = r_out.error_code;

endmodule

`default_nettype wire

// ===== hw/rtl/exptok_lex.sv =====
// Per-character lexer logic: classifies one character against the run state
// and the operator masks, giving the token and the next run state.
// Depends on exptok_pkg.
`timescale 1ns / 1ps
`default_nettype none

module exptok_lex
    import exptok_pkg::*;
(
    input  wire logic [7:0]  i_symbol,
    input  wire logic        i_expression_start,
    input  wire t_lex_state  i_state,
    input  wire logic [63:0] i_mask_low,
    input  wire logic [63:0] i_mask_high,
    output t_lex_state       o_state,
    output logic             o_emit,
    output t_token           o_token
);

    t_lex_state s;
    logic       is_digit;
    logic       is_letter;
    logic       is_bracket;
    logic       is_op;

    assign is_digit   = (i_symbol >= CH_ZERO) && (i_symbol <= CH_NINE);
    assign is_letter  = (i_symbol >= CH_LOW_A) && (i_symbol <= CH_LOW_Z);
    assign is_bracket = (i_symbol == CH_LPAREN) || (i_symbol == CH_RPAREN);
    assign is_op      = !i_symbol[7] &&
                        (i_symbol[6] ? i_mask_high[i_symbol[5:0]]
                                     : i_mask_low[i_symbol[5:0]]);

    always_comb begin
        s = i_state;
        if (i_expression_start) begin
            s.after_operator = 1'b1;
            s.run_kind       = RUN_NONE;
            s.dot_seen       = 1'b0;
            s.failed         = 1'b0;
        end
        o_state             = s;
        o_emit              = 1'b0;
        o_token.token_char  = i_symbol;
        o_token.token_start = 1'b0;
        o_token.token_kind  = KIND_NUMBER;
        o_token.error_code  = ERR_NONE;

        if (s.failed) begin
            o_emit = 1'b0;
        end else if (i_symbol == CH_SPACE) begin
            o_state.run_kind       = RUN_NONE;
            o_state.after_operator = 1'b0;
        end else if (s.run_kind == RUN_NUMBER && i_symbol == CH_DOT) begin
            o_emit = 1'b1;
            if (s.dot_seen) begin
                o_state.failed     = 1'b1;
                o_token.error_code = ERR_DOTS;
            end else begin
                o_state.dot_seen = 1'b1;
            end
        end else if (is_digit) begin
            o_emit                 = 1'b1;
            o_token.token_start    = (s.run_kind != RUN_NUMBER);
            if (s.run_kind != RUN_NUMBER) begin
                o_state.dot_seen = 1'b0;
            end
            o_state.run_kind       = RUN_NUMBER;
            o_state.after_operator = 1'b0;
        end else if (is_letter) begin
            o_emit                 = 1'b1;
            o_token.token_start    = (s.run_kind != RUN_NAME);
            o_token.token_kind     = KIND_NAME;
            o_state.run_kind       = RUN_NAME;
            o_state.after_operator = 1'b0;
        end else if (is_bracket) begin
            o_emit                 = 1'b1;
            o_token.token_start    = 1'b1;
            o_token.token_kind     = KIND_BRACKET;
            o_state.run_kind       = RUN_NONE;
            o_state.after_operator = 1'b0;
        end else if (is_op) begin
            o_emit              = 1'b1;
            o_token.token_start = 1'b1;
            o_token.token_kind  = KIND_OPERATOR;
            // A sign right after an operator or at expression start is unary.
            if (s.after_operator && i_symbol == CH_MINUS) begin
                o_token.token_char = CH_TILDE;
            end else if (s.after_operator && i_symbol == CH_PLUS) begin
                o_token.token_char = CH_HASH;
            end
            o_state.run_kind       = RUN_NONE;
            o_state.after_operator = 1'b1;
        end else begin
            o_emit             = 1'b1;
            o_token.error_code = ERR_UNKNOWN;
            o_state.failed     = 1'b1;
            o_state.run_kind   = RUN_NONE;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/exptok_checker.sv =====
// Port-level checks for the expression tokenizer and the bind that attaches
// them to the top level. Depends on exptok_pkg and expression_tokenizer.
`timescale 1ns / 1ps
`default_nettype none

module exptok_checker
    import exptok_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       i_ready,
    input wire logic [7:0] i_token_char,
    input wire logic       i_token_start,
    input wire logic [1:0] i_token_kind,
    input wire logic [1:0] i_error_code
);

    // No token may be offered in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("token valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_token_char) && $stable(i_token_kind))
        else $error("stalled token changed");

    // An error word never opens a token and carries the number kind.
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_error_code != ERR_NONE |-> !i_token_start && i_token_kind == KIND_NUMBER)
        else $error("malformed error token");

    // Brackets are always single-character tokens without error.
    a_bracket_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_token_kind == KIND_BRACKET |->
            i_token_start && i_error_code == ERR_NONE &&
            (i_token_char == CH_LPAREN || i_token_char == CH_RPAREN))
        else $error("malformed bracket token");

endmodule

bind expression_tokenizer exptok_checker u_exptok_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_tok.valid),
    .i_ready       (o_tok.ready),
    .i_token_char  (o_tok.token_char),
    .i_token_start (o_tok.token_start),
    .i_token_kind  (o_tok.token_kind),
    .i_error_code  (o_tok.error_code)
);

`default_nettype wire
